// ===== src/rfss_pkg.sv =====
// Shared types and constants for the RF supply supervision timers.
`default_nettype none

package rfss_pkg;

    localparam int CFG_W       = 16;
    localparam int OFF_TIMER_W = 26;
    localparam int MS_W        = 10;
    localparam int SECONDS_W   = 32;
    localparam int FAN_STEP_W  = 6;
    localparam int DUTY_W      = 7;
    localparam int PHASE_W     = 9;
    localparam int CMD_W       = 3;
    localparam int PADDR_W     = 4;
    localparam int PDATA_W     = 32;
    localparam int REG_IDX_W   = 2;

    // Default timing figures.
    localparam int PWM_PERIOD_DEF       = 40;
    localparam int TICKS_PER_SECOND_DEF = 1000;
    localparam int FAN_STEP_TICKS_DEF   = 50;
    localparam int FAN_MAX_DUTY_DEF     = 90;

    // The duty cycle is given in percent.
    localparam int PWM_SCALE = 100;

    typedef enum logic [CMD_W-1:0] {
        CMD_MS_TICK        = 3'd0,
        CMD_PWM_TICK       = 3'd1,
        CMD_SET_SLOW_START = 3'd2,
        CMD_SET_SLOW_STOP  = 3'd3,
        CMD_SET_OFF_DELAY  = 3'd4,
        CMD_CLEAR_TIMEOUT  = 3'd5
    } t_command;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_SLOW_START_DELAY    = 2'd0,
        REG_SLOW_STOP_DELAY     = 2'd1,
        REG_REFLECT_OFF_DELAY_S = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic             flag_value;
        logic             rf_on;
    } t_cmd_item;

    typedef struct packed {
        logic [CFG_W-1:0]     slow_start_count;
        logic [CFG_W-1:0]     slow_stop_count;
        logic                 slow_start_enabled;
        logic                 slow_stop_enabled;
        logic                 off_delay_active;
        logic                 off_timeout;
        logic [SECONDS_W-1:0] rf_on_seconds;
        logic                 fan_ramp_done;
        logic [DUTY_W-1:0]    fan_duty;
        logic                 fan_pin;
    } t_result_item;

    // Register values as the timer core sees them; the off limit is already in ms ticks.
    typedef struct packed {
        logic [CFG_W-1:0]       slow_start_delay;
        logic [CFG_W-1:0]       slow_stop_delay;
        logic [OFF_TIMER_W-1:0] off_limit;
    } t_cfg;

endpackage

`default_nettype wire

// ===== src/rfss_if.sv =====
// Valid/ready channel interfaces for command requests and result requests.
`default_nettype none

interface rfss_cmd_if;
    import rfss_pkg::*;

    logic      valid;
    logic      ready;
    t_cmd_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface rfss_res_if;
    import rfss_pkg::*;

    logic         valid;
    logic         ready;
    t_result_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== src/rfss_cfg_regs.sv =====
// APB-style configuration registers for the supervision timers.
`default_nettype none

module rfss_cfg_regs #(
    parameter int TICKS_PER_SECOND = rfss_pkg::TICKS_PER_SECOND_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [rfss_pkg::PADDR_W-1:0] paddr,
    input  wire logic [rfss_pkg::PDATA_W-1:0] pwdata,
    output logic      [rfss_pkg::PDATA_W-1:0] prdata,
    output logic                              pready,
    output rfss_pkg::t_cfg                    o_cfg
);
    import rfss_pkg::*;

    logic [CFG_W-1:0]       r_slow_start_delay;
    logic [CFG_W-1:0]       r_slow_stop_delay;
    logic [CFG_W-1:0]       r_reflect_off_delay_s;
    logic [OFF_TIMER_W-1:0] r_off_limit;
    logic                   w_write;
    t_reg_idx               w_idx;

    assign pready  = 1'b1;
    assign w_write = psel && penable && pwrite && pready;
    assign w_idx   = t_reg_idx'(paddr[REG_IDX_W+1:2]);

    // The off limit is converted to ms ticks when the register is written.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slow_start_delay    <= '0;
            r_slow_stop_delay     <= '0;
            r_reflect_off_delay_s <= '0;
            r_off_limit           <= '0;
        end else if (w_write) begin
            unique case (w_idx)
                REG_SLOW_START_DELAY: begin
                    r_slow_start_delay <= pwdata[CFG_W-1:0];
                end
                REG_SLOW_STOP_DELAY: begin
                    r_slow_stop_delay <= pwdata[CFG_W-1:0];
                end
                REG_REFLECT_OFF_DELAY_S: begin
                    r_reflect_off_delay_s <= pwdata[CFG_W-1:0];
                    r_off_limit <= OFF_TIMER_W'(pwdata[CFG_W-1:0])
                                 * OFF_TIMER_W'(TICKS_PER_SECOND);
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_SLOW_START_DELAY:    prdata = PDATA_W'(r_slow_start_delay);
            REG_SLOW_STOP_DELAY:     prdata = PDATA_W'(r_slow_stop_delay);
            REG_REFLECT_OFF_DELAY_S: prdata = PDATA_W'(r_reflect_off_delay_s);
            default:                 prdata = '0;
        endcase
    end

    assign o_cfg.slow_start_delay = r_slow_start_delay;
    assign o_cfg.slow_stop_delay  = r_slow_stop_delay;
    assign o_cfg.off_limit        = r_off_limit;

endmodule

`default_nettype wire

// ===== src/rfss_timer_core.sv =====
// Timer state and its single-pass update for one command request.
`default_nettype none

module rfss_timer_core #(
    parameter int PWM_PERIOD       = rfss_pkg::PWM_PERIOD_DEF,
    parameter int TICKS_PER_SECOND = rfss_pkg::TICKS_PER_SECOND_DEF,
    parameter int FAN_STEP_TICKS   = rfss_pkg::FAN_STEP_TICKS_DEF,
    parameter int FAN_MAX_DUTY     = rfss_pkg::FAN_MAX_DUTY_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_fire,
    input  wire rfss_pkg::t_cmd_item i_item,
    input  wire rfss_pkg::t_cfg      i_cfg,
    output rfss_pkg::t_result_item   o_next
);
    import rfss_pkg::*;

    localparam int DUTY_DEPTH = 2 ** DUTY_W;

    logic                   r_start_flag, n_start_flag;
    logic                   r_stop_flag, n_stop_flag;
    logic                   r_off_flag, n_off_flag;
    logic                   r_timeout, n_timeout;
    logic [CFG_W-1:0]       r_start_timer, n_start_timer;
    logic [CFG_W-1:0]       r_stop_timer, n_stop_timer;
    logic [OFF_TIMER_W-1:0] r_off_timer, n_off_timer;
    logic [MS_W-1:0]        r_ms, n_ms;
    logic [SECONDS_W-1:0]   r_seconds, n_seconds;
    logic [FAN_STEP_W-1:0]  r_fan_step, n_fan_step;
    logic [DUTY_W-1:0]      r_duty, n_duty;
    logic                   r_ramp_done, n_ramp_done;
    logic [PHASE_W-1:0]     r_phase, n_phase;
    logic                   r_pin, n_pin;

    logic [PHASE_W-1:0]     w_thresh_tab [DUTY_DEPTH];
    logic [MS_W-1:0]        w_ms_inc;
    logic [OFF_TIMER_W-1:0] w_off_inc;
    logic [CFG_W:0]         w_start_inc;
    logic [FAN_STEP_W-1:0]  w_fan_inc;
    logic [DUTY_W-1:0]      w_duty_base;
    logic [PHASE_W-1:0]     w_phase_inc;

    // PWM match threshold for every duty value, built at elaboration.
    for (genvar d = 0; d < DUTY_DEPTH; d++) begin : g_thresh
        assign w_thresh_tab[d] = PHASE_W'((d * PWM_PERIOD) / PWM_SCALE);
    end

    assign w_ms_inc    = r_ms + 1'b1;
    assign w_off_inc   = r_off_timer + 1'b1;
    assign w_start_inc = {1'b0, r_start_timer} + 1'b1;
    assign w_fan_inc   = r_fan_step + 1'b1;
    assign w_phase_inc = r_phase + 1'b1;
    assign w_duty_base = (r_duty >= DUTY_W'(FAN_MAX_DUTY)) ? DUTY_W'(FAN_MAX_DUTY) : r_duty;

    always_comb begin
        n_start_flag  = r_start_flag;
        n_stop_flag   = r_stop_flag;
        n_off_flag    = r_off_flag;
        n_timeout     = r_timeout;
        n_start_timer = r_start_timer;
        n_stop_timer  = r_stop_timer;
        n_off_timer   = r_off_timer;
        n_ms          = r_ms;
        n_seconds     = r_seconds;
        n_fan_step    = r_fan_step;
        n_duty        = r_duty;
        n_ramp_done   = r_ramp_done;
        n_phase       = r_phase;
        n_pin         = r_pin;

        unique case (t_command'(i_item.command))
            CMD_MS_TICK: begin
                // RF-off clears the seconds count but leaves the ms phase where it is.
                if (i_item.rf_on) begin
                    if (w_ms_inc >= MS_W'(TICKS_PER_SECOND)) begin
                        n_ms      = '0;
                        n_seconds = r_seconds + 1'b1;
                    end else begin
                        n_ms = w_ms_inc;
                    end
                end else begin
                    n_seconds = '0;
                end

                if (r_off_flag) begin
                    n_off_timer = w_off_inc;
                    if (w_off_inc >= i_cfg.off_limit) begin
                        n_off_flag = 1'b0;
                        n_timeout  = 1'b1;
                    end
                end else begin
                    n_off_timer = '0;
                end

                if (r_start_flag) begin
                    if (w_start_inc >= {1'b0, i_cfg.slow_start_delay}) begin
                        n_start_timer = i_cfg.slow_start_delay;
                    end else begin
                        n_start_timer = w_start_inc[CFG_W-1:0];
                    end
                end else begin
                    n_start_timer = '0;
                end

                if (r_stop_flag) begin
                    if (r_stop_timer != '0) begin
                        n_stop_timer = r_stop_timer - 1'b1;
                    end
                end else begin
                    n_stop_timer = i_cfg.slow_stop_delay;
                end

                // Once at the maximum, the step still adds one, so the duty rests one above it.
                if (w_fan_inc >= FAN_STEP_W'(FAN_STEP_TICKS)) begin
                    n_fan_step = '0;
                    n_duty     = w_duty_base + 1'b1;
                    if (r_duty >= DUTY_W'(FAN_MAX_DUTY)) begin
                        n_ramp_done = 1'b1;
                    end
                end else begin
                    n_fan_step = w_fan_inc;
                end
            end
            CMD_PWM_TICK: begin
                if (w_phase_inc == w_thresh_tab[r_duty]) begin
                    n_phase = w_phase_inc;
                    n_pin   = 1'b1;
                end else if (w_phase_inc > PHASE_W'(PWM_PERIOD)) begin
                    n_phase = '0;
                    n_pin   = 1'b0;
                end else begin
                    n_phase = w_phase_inc;
                end
            end
            CMD_SET_SLOW_START: n_start_flag = i_item.flag_value;
            CMD_SET_SLOW_STOP:  n_stop_flag  = i_item.flag_value;
            CMD_SET_OFF_DELAY:  n_off_flag   = i_item.flag_value;
            CMD_CLEAR_TIMEOUT:  n_timeout    = 1'b0;
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_flag  <= 1'b0;
            r_stop_flag   <= 1'b0;
            r_off_flag    <= 1'b0;
            r_timeout     <= 1'b0;
            r_start_timer <= '0;
            r_stop_timer  <= '0;
            r_off_timer   <= '0;
            r_ms          <= '0;
            r_seconds     <= '0;
            r_fan_step    <= '0;
            r_duty        <= '0;
            r_ramp_done   <= 1'b0;
            r_phase       <= '0;
            r_pin         <= 1'b0;
        end else if (i_fire) begin
            r_start_flag  <= n_start_flag;
            r_stop_flag   <= n_stop_flag;
            r_off_flag    <= n_off_flag;
            r_timeout     <= n_timeout;
            r_start_timer <= n_start_timer;
            r_stop_timer  <= n_stop_timer;
            r_off_timer   <= n_off_timer;
            r_ms          <= n_ms;
            r_seconds     <= n_seconds;
            r_fan_step    <= n_fan_step;
            r_duty        <= n_duty;
            r_ramp_done   <= n_ramp_done;
            r_phase       <= n_phase;
            r_pin         <= n_pin;
        end
    end

    assign o_next.slow_start_count   = n_start_timer;
    assign o_next.slow_stop_count    = n_stop_timer;
    assign o_next.slow_start_enabled = n_start_flag;
    assign o_next.slow_stop_enabled  = n_stop_flag;
    assign o_next.off_delay_active   = n_off_flag;
    assign o_next.off_timeout        = n_timeout;
    assign o_next.rf_on_seconds      = n_seconds;
    assign o_next.fan_ramp_done      = n_ramp_done;
    assign o_next.fan_duty           = n_duty;
    assign o_next.fan_pin            = n_pin;

    a_duty_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_duty <= DUTY_W'(FAN_MAX_DUTY + 1))
        else $error("fan duty ran past its resting value");

    a_phase_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase <= PHASE_W'(PWM_PERIOD + 1))
        else $error("PWM phase ran past its period");

    a_timeout_on_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_timeout) |-> $past(i_fire && (i_item.command == CMD_MS_TICK)))
        else $error("timeout raised outside a millisecond tick");

    a_expiry_sets_timeout: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($fell(r_off_flag) && $past(i_fire && (i_item.command == CMD_MS_TICK)))
        |-> r_timeout)
        else $error("off delay expired without raising timeout");

endmodule

`default_nettype wire

// ===== src/rf_supply_supervision_timers_unit.sv =====
// A command request is taken into the input register; when the result register is empty
// or its result is taken, the core updates and the result waits in the result register.
// Throughput: one command per cycle while results are taken; the input and result
// registers let a new command enter while the previous result still waits to be taken.
// Reset (synchronous, active low) clears all timers, flags, config and both valid bits.
`default_nettype none

module rf_supply_supervision_timers_unit #(
    parameter int PWM_PERIOD       = rfss_pkg::PWM_PERIOD_DEF,
    parameter int TICKS_PER_SECOND = rfss_pkg::TICKS_PER_SECOND_DEF,
    parameter int FAN_STEP_TICKS   = rfss_pkg::FAN_STEP_TICKS_DEF,
    parameter int FAN_MAX_DUTY     = rfss_pkg::FAN_MAX_DUTY_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    rfss_cmd_if.sink                          i_cmd,
    rfss_res_if.source                        o_res,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [rfss_pkg::PADDR_W-1:0] paddr,
    input  wire logic [rfss_pkg::PDATA_W-1:0] pwdata,
    output logic      [rfss_pkg::PDATA_W-1:0] prdata,
    output logic                              pready
);
    import rfss_pkg::*;

    logic         r_in_valid;
    t_cmd_item    r_in_data;
    logic         r_out_valid;
    t_result_item r_out_data;
    logic         w_advance;
    logic         w_in_ready;
    t_cfg         w_cfg;
    t_result_item w_next;

    assign w_advance  = r_in_valid && (!r_out_valid || o_res.ready);
    assign w_in_ready = !r_in_valid || w_advance;

    assign i_cmd.ready = w_in_ready;
    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out_data;

    rfss_cfg_regs #(
        .TICKS_PER_SECOND (TICKS_PER_SECOND)
    ) u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    rfss_timer_core #(
        .PWM_PERIOD       (PWM_PERIOD),
        .TICKS_PER_SECOND (TICKS_PER_SECOND),
        .FAN_STEP_TICKS   (FAN_STEP_TICKS),
        .FAN_MAX_DUTY     (FAN_MAX_DUTY)
    ) u_timer_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (w_advance),
        .i_item  (r_in_data),
        .i_cfg   (w_cfg),
        .o_next  (w_next)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_ready) begin
                r_in_valid <= i_cmd.valid;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_ready && i_cmd.valid) begin
            r_in_data <= i_cmd.data;
        end
        if (w_advance) begin
            r_out_data <= w_next;
        end
    end

endmodule

`default_nettype wire
